@@ hdl/cda_pkg.sv @@
// Shared types and constants of the cosine distance accumulator.
package cda_pkg;

    // Elements are signed Q3.12; products are Q7.24.
    localparam int ELEM_W     = 16;
    localparam int DOT_PROD_W = 32;   // signed a*b
    localparam int SQR_PROD_W = 31;   // unsigned a*a, b*b

    // Decoupling queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Fraction bits appended before the square roots.
    localparam int SQRT_SHIFT = 16;

    // Quotient bits of cos * 2^17 and their step counter.
    localparam int DIV_STEPS = 33;
    localparam int DIV_CNT_W = 6;

    localparam int DIST_W = 18;
    localparam logic [DIST_W-1:0] DIST_ONE = 18'd65536;

    typedef struct packed {
        logic signed [DOT_PROD_W-1:0] dot;
        logic [SQR_PROD_W-1:0]        aa;
        logic [SQR_PROD_W-1:0]        bb;
        logic                         add_en;
        logic                         last;
        logic                         too_long;
    } t_qentry;

endpackage

@@ hdl/cda_front.sv @@
// Front end: accepts element pairs, counts them against the length limit, forms products.
module cda_front
    import cda_pkg::*;
#(
    parameter int MAX_LEN = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic signed [ELEM_W-1:0] i_elem_a,
    input  logic signed [ELEM_W-1:0] i_elem_b,
    input  logic                     i_last,
    input  logic                     i_full,
    output logic                     o_in_stall,
    output logic                     o_push,
    output t_qentry                  o_entry
);
    localparam int CNT_W = $clog2(MAX_LEN + 1);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    logic             w_add;
    logic             w_too_long;
    logic signed [DOT_PROD_W-1:0] w_ab;
    logic signed [DOT_PROD_W-1:0] w_aa;
    logic signed [DOT_PROD_W-1:0] w_bb;

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    assign w_add      = (r_cnt != CNT_W'(MAX_LEN));
    assign w_too_long = r_ovf || !w_add;

    assign w_ab = DOT_PROD_W'(i_elem_a) * DOT_PROD_W'(i_elem_b);
    assign w_aa = DOT_PROD_W'(i_elem_a) * DOT_PROD_W'(i_elem_a);
    assign w_bb = DOT_PROD_W'(i_elem_b) * DOT_PROD_W'(i_elem_b);

    always_comb begin
        o_entry.dot      = w_ab;
        o_entry.aa       = w_aa[SQR_PROD_W-1:0];
        o_entry.bb       = w_bb[SQR_PROD_W-1:0];
        o_entry.add_en   = w_add;
        o_entry.last     = i_last;
        o_entry.too_long = w_too_long;
    end

    always_comb begin
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        if (o_push) begin
            if (i_last) begin
                n_cnt = '0;
                n_ovf = 1'b0;
            end else begin
                n_cnt = r_cnt + CNT_W'(w_add);
                n_ovf = w_too_long;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
        end
    end

endmodule

@@ hdl/cda_queue.sv @@
// Short FIFO of classified pairs between front and back.
module cda_queue
    import cda_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_qentry i_entry,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_valid,
    output t_qentry o_head
);
    t_qentry           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

endmodule

@@ hdl/cda_sqrt.sv @@
// Iterative integer square root, one root bit per cycle.
module cda_sqrt #(
    parameter int SQ_W = 29
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [2*SQ_W-1:0] i_value,
    output logic              o_done,
    output logic [SQ_W-1:0]   o_root
);
    localparam int CNT_W = $clog2(SQ_W + 1);

    logic [2*SQ_W-1:0] r_val;
    logic [SQ_W+1:0]   r_rem;
    logic [SQ_W-1:0]   r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [SQ_W+1:0]   w_rem_sh;
    logic [SQ_W+1:0]   w_trial;
    logic              w_ge;

    assign w_rem_sh = {r_rem[SQ_W-1:0], r_val[2*SQ_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);
    assign o_done   = r_done;
    assign o_root   = r_root;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[2*SQ_W-3:0], 2'b00};
            r_rem  <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
            r_root <= {r_root[SQ_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQ_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

@@ hdl/cda_back.sv @@
// Back end: accumulates sums, then computes the distance with sqrt, multiply and long division.
module cda_back
    import cda_pkg::*;
#(
    parameter int NORM_W = 42,
    parameter int DOT_W  = 43,
    parameter int SQ_W   = 29
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_qentry           i_q_head,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DIST_W-1:0] o_distance,
    output logic              o_zero_norm,
    output logic              o_too_long
);
    localparam int DEN_W = 2 * SQ_W;
    localparam int ST_W  = 4;

    localparam logic [ST_W-1:0] S_ACC = 4'd0;
    localparam logic [ST_W-1:0] S_STA = 4'd1;
    localparam logic [ST_W-1:0] S_WTA = 4'd2;
    localparam logic [ST_W-1:0] S_STB = 4'd3;
    localparam logic [ST_W-1:0] S_WTB = 4'd4;
    localparam logic [ST_W-1:0] S_MUL = 4'd5;
    localparam logic [ST_W-1:0] S_CMP = 4'd6;
    localparam logic [ST_W-1:0] S_DIV = 4'd7;
    localparam logic [ST_W-1:0] S_FIN = 4'd8;
    localparam logic [ST_W-1:0] S_OUT = 4'd9;

    logic [ST_W-1:0]          r_state;
    logic signed [DOT_W-1:0]  r_dot;
    logic [NORM_W-1:0]        r_na, r_nb;
    logic [SQ_W-1:0]          r_sa;
    logic [DEN_W-1:0]         r_den, r_mag;
    logic [DEN_W:0]           r_rem;
    logic [DIV_STEPS-1:0]     r_q;
    logic [DIV_CNT_W-1:0]     r_dcnt;
    logic                     r_neg;
    logic [DIST_W-1:0]        r_dist;
    logic                     r_zero, r_tl;

    logic                     w_sq_start;
    logic [DEN_W-1:0]         w_sq_in;
    logic                     w_sq_done;
    logic [SQ_W-1:0]          w_sq_root;
    logic [DEN_W-1:0]         w_prod;
    logic [DOT_W-1:0]         w_mag;
    logic [DEN_W:0]           w_rem_sh;
    logic                     w_ge;
    logic [DIV_STEPS:0]       w_qp1;
    logic [DIV_STEPS-1:0]     w_c;
    logic [DIST_W-1:0]        w_csat;

    assign o_q_pop     = i_q_valid && (r_state == S_ACC);
    assign o_out_valid = (r_state == S_OUT);
    assign o_distance  = r_dist;
    assign o_zero_norm = r_zero;
    assign o_too_long  = r_tl;

    assign w_sq_start = (r_state == S_STA && r_na != '0 && r_nb != '0) || (r_state == S_STB);
    assign w_sq_in    = (r_state == S_STB) ? DEN_W'({r_nb, {SQRT_SHIFT{1'b0}}})
                                           : DEN_W'({r_na, {SQRT_SHIFT{1'b0}}});

    cda_sqrt #(.SQ_W(SQ_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_value (w_sq_in),
        .o_done  (w_sq_done),
        .o_root  (w_sq_root)
    );

    assign w_prod   = r_sa * w_sq_root;
    assign w_mag    = r_dot[DOT_W-1] ? (DOT_W'(0) - DOT_W'(r_dot)) : DOT_W'(r_dot);
    assign w_rem_sh = {r_rem[DEN_W-1:0], 1'b0};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});
    assign w_qp1    = {1'b0, r_q} + 1'b1;
    assign w_c      = w_qp1[DIV_STEPS:1];
    assign w_csat   = (w_c > DIV_STEPS'(DIST_ONE)) ? DIST_ONE : w_c[DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_dot   <= '0;
            r_na    <= '0;
            r_nb    <= '0;
        end else begin
            case (r_state)
                S_ACC: begin
                    if (o_q_pop) begin
                        if (i_q_head.add_en) begin
                            r_dot <= r_dot + DOT_W'(i_q_head.dot);
                            r_na  <= r_na + NORM_W'(i_q_head.aa);
                            r_nb  <= r_nb + NORM_W'(i_q_head.bb);
                        end
                        if (i_q_head.last) begin
                            r_tl    <= i_q_head.too_long;
                            r_state <= S_STA;
                        end
                    end
                end
                S_STA: begin
                    // Zero norm: skip the arithmetic.
                    if (r_na == '0 || r_nb == '0) begin
                        r_dist  <= '0;
                        r_zero  <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_zero  <= 1'b0;
                        r_state <= S_WTA;
                    end
                end
                S_WTA: begin
                    if (w_sq_done) begin
                        r_sa    <= w_sq_root;
                        r_state <= S_STB;
                    end
                end
                S_STB: begin
                    r_state <= S_WTB;
                end
                S_WTB: begin
                    if (w_sq_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_den   <= w_prod;
                    r_neg   <= r_dot[DOT_W-1];
                    r_mag   <= DEN_W'(w_mag);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_mag >= r_den) begin
                        r_dist  <= r_neg ? (DIST_ONE + DIST_ONE) : '0;
                        r_state <= S_OUT;
                    end else begin
                        r_rem   <= {1'b0, r_mag};
                        r_q     <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= w_ge ? (w_rem_sh - {1'b0, r_den}) : w_rem_sh;
                    r_q    <= {r_q[DIV_STEPS-2:0], w_ge};
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_dist  <= r_neg ? (DIST_ONE + w_csat) : (DIST_ONE - w_csat);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_dot   <= '0;
                        r_na    <= '0;
                        r_nb    <= '0;
                        r_state <= S_ACC;
                    end
                end
                default: begin
                    r_state <= S_ACC;
                end
            endcase
        end
    end

endmodule

@@ hdl/cosine_distance_accumulator.sv @@
// Top level of the cosine distance accumulator.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------------
//   in      | input     | i_in_valid / o_in_stall | i_elem_a, i_elem_b, i_last
//   out     | output    | o_out_valid/i_out_stall | o_distance, o_zero_norm, o_too_long
//
// Element pair transactions are taken one per cycle while the queue has room; the
// back end adds one pair per cycle while accumulating. A last pair starts the finish
// (two iterative square roots of SQ_W steps each, one multiply, 33 division steps);
// the front keeps taking pairs into the queue meanwhile, until the queue is full.
// Reset is synchronous, active low, and clears counts, sums, queue pointers and state.
// A stalled result holds in the output register; a full queue stalls the input.
module cosine_distance_accumulator
    import cda_pkg::*;
#(
    parameter int MAX_LEN = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [ELEM_W-1:0] i_elem_a,
    input  logic signed [ELEM_W-1:0] i_elem_b,
    input  logic                     i_last,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [DIST_W-1:0]        o_distance,
    output logic                     o_zero_norm,
    output logic                     o_too_long
);
    // Norm sums hold MAX_LEN squares of up to 2^30; the dot sum needs one sign bit more.
    localparam int NORM_W = 31 + $clog2(MAX_LEN + 1);
    localparam int DOT_W  = NORM_W + 1;
    // Root width of a norm with 16 fraction bits appended.
    localparam int SQ_W   = (NORM_W + SQRT_SHIFT + 1) / 2;

    logic    w_full;
    logic    w_push;
    t_qentry w_entry;
    logic    w_q_valid;
    logic    w_q_pop;
    t_qentry w_q_head;

    // Classify each pair: inside the length limit or beyond it (not added to the sums).
    cda_front #(.MAX_LEN(MAX_LEN)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_elem_a   (i_elem_a),
        .i_elem_b   (i_elem_b),
        .i_last     (i_last),
        .i_full     (w_full),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_entry    (w_entry)
    );

    // Decouple input stalls from the long finishing computation.
    cda_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_q_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_head  (w_q_head)
    );

    // Accumulate, then finish the distance and hold it until taken.
    cda_back #(
        .NORM_W (NORM_W),
        .DOT_W  (DOT_W),
        .SQ_W   (SQ_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_head    (w_q_head),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_distance  (o_distance),
        .o_zero_norm (o_zero_norm),
        .o_too_long  (o_too_long)
    );

endmodule

@@ hdl/cda_checker.sv @@
// Port-level checks of the cosine distance accumulator, bound to the top level.
module cda_checker
    import cda_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [DIST_W-1:0] o_distance,
    input logic              o_zero_norm,
    input logic              o_too_long
);
    // Hold a stalled result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_distance)
            && $stable(o_zero_norm) && $stable(o_too_long))
        else $error("stalled result changed");

    // Zero norm forces distance zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_norm |-> o_distance == '0)
        else $error("zero norm with nonzero distance");

    // Distance stays within 0..2.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_distance <= (DIST_ONE + DIST_ONE))
        else $error("distance out of range");

    // A delivered result cannot be followed by another in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall |=> !o_out_valid)
        else $error("back-to-back results");

endmodule

bind cosine_distance_accumulator cda_checker u_cda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_distance  (o_distance),
    .o_zero_norm (o_zero_norm),
    .o_too_long  (o_too_long)
);
